/* src/chd_pkg.sv */
// Shared types, command and status codes, and bit-reversal helpers
// for the canonical Huffman decoder. No dependencies.
package chd_pkg;

	// command codes carried by a request
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_BUILD  = 2'd2,
		CMD_DECODE = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TOOMANY = 2'd1,
		ST_OVERSUB = 2'd2,
		ST_BADCODE = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [8:0]  symbol;
		logic [3:0]  code_length;
		logic [15:0] bit_window;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [8:0] decoded_symbol;
		logic [3:0] consumed_bits;
	} rsp_t;

	// longest code length handled (code_length is 4 bits wide)
	localparam int MAX_LEN = 15;

	// full 16-bit reversal
	function automatic logic [15:0] rev16(input logic [15:0] v);
		logic [15:0] r;
		for (int k = 0; k < 16; k++) begin
			r[k] = v[15-k];
		end
		return r;
	endfunction

	// reverse the low n bits of v (n in 1..15)
	function automatic logic [15:0] rev_n(input logic [15:0] v, input logic [3:0] n);
		logic [4:0] sh;
		sh = 5'd16 - {1'b0, n};
		return rev16(v) >> sh;
	endfunction

endpackage

/* src/canonical_huffman_decoder.sv */
// Canonical Huffman decoder top level: length store, table build sequencer
// and decode sequencer. Depends on chd_pkg.
//
// channel | ports                  | handshake
// --------+------------------------+--------------------------------------
// request | start, req (req_t)     | taken when start && !busy
// result  | done, result (rsp_t)   | one-cycle strobe, cannot be stalled
//
// Decode: a fast-table hit answers from S_DFAST; a miss searches the
// lengths from FAST_LOOKUP_BITS+1 upward, then checks the sorted index
// (S_DIDX) and reads the sorted tables (S_DCHK). Load answers at once.
// Clear sweeps the length store. Build runs fast clear, count, check,
// generate and fill, with one fast-table write per replicated slot.
// After reset a clearing pass runs with busy high. The receiver cannot
// stall results.
module canonical_huffman_decoder import chd_pkg::*; #(
	parameter int FAST_LOOKUP_BITS = 9,
	parameter int SYMBOL_COUNT     = 288
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t result
);

	localparam int FAST_SIZE  = 1 << FAST_LOOKUP_BITS;
	localparam int MAXD       = (SYMBOL_COUNT > FAST_SIZE) ? SYMBOL_COUNT : FAST_SIZE;
	localparam int CW         = $clog2(MAXD + 1);
	localparam int SW         = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int CNTW       = $clog2(SYMBOL_COUNT + 1);
	localparam int RW         = FAST_LOOKUP_BITS + 1;
	localparam int SLOW_FIRST = FAST_LOOKUP_BITS + 1;

	typedef enum logic [3:0] {
		S_RCLR, S_IDLE, S_CCLR, S_BFCLR, S_CNT, S_CHK, S_GEN,
		S_FRD, S_FLEN, S_FFAST, S_DFAST, S_DSRCH, S_DIDX, S_DCHK
	} state_t;

	state_t state_q;
	logic [CW-1:0]   i_q;
	logic [3:0]      len_q;
	logic [16:0]     code_q;
	logic [CNTW-1:0] total_q;
	logic [RW-1:0]   r_q;
	logic [15:0]     win_q;
	logic [15:0]     rev_q;
	logic signed [17:0] idx_q;
	logic            done_q;
	rsp_t            result_q;

	logic [CNTW-1:0] counts_q     [16];
	logic [15:0]     next_code_q  [16];
	logic [15:0]     first_code_q [16];
	logic [CNTW-1:0] first_index_q[16];
	logic [16:0]     max_code_q   [16];

	// memories
	logic [3:0]  length_store  [SYMBOL_COUNT];
	logic [3:0]  sorted_lengths[SYMBOL_COUNT];
	logic [8:0]  sorted_symbols[SYMBOL_COUNT];
	logic [12:0] fast_table    [FAST_SIZE];

	logic [3:0]  ls_rd_q;
	logic [3:0]  sl_rd_q;
	logic [8:0]  ss_rd_q;
	logic [12:0] ft_rd_q;

	logic                         ls_we, sl_we, ss_we, ft_we;
	logic [SW-1:0]                ls_waddr, sl_waddr;
	logic [3:0]                   ls_wdata, sl_wdata;
	logic [FAST_LOOKUP_BITS-1:0]  ft_waddr;
	logic [12:0]                  ft_wdata;

	logic                accept;
	logic                i_last_sym, i_last_fast, i_last_all;
	logic [8:0]          cur_sym;
	logic [17:0]         fill_idx;
	logic                fill_idx_ok;
	logic [16:0]         code_new;
	logic [4:0]          len_shift;
	logic signed [17:0]  idx_slow;
	logic [RW-1:0]       r_next;

	assign accept      = start && !busy;
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign result      = result_q;
	assign i_last_sym  = (i_q == CW'(SYMBOL_COUNT - 1));
	assign i_last_fast = (i_q == CW'(FAST_SIZE - 1));
	assign i_last_all  = (i_q == CW'(MAXD - 1));
	assign cur_sym     = 9'(i_q[SW-1:0]);

	// sorted index of the current symbol during the fill
	assign fill_idx    = 18'(next_code_q[ls_rd_q]) - 18'(first_code_q[ls_rd_q])
	                   + 18'(first_index_q[ls_rd_q]);
	assign fill_idx_ok = (fill_idx < 18'(SYMBOL_COUNT));

	// code generation step for length len_q
	assign code_new  = code_q + 17'(counts_q[len_q]);
	assign len_shift = 5'd16 - {1'b0, len_q};

	// sorted index for the slow search hit
	assign idx_slow = $signed(18'(rev_q >> len_shift)) - $signed(18'(first_code_q[len_q]))
	                + $signed(18'(first_index_q[len_q]));

	assign r_next = r_q + (RW'(1) << ls_rd_q);

	// write port selection
	always_comb begin
		ls_we    = 1'b0;
		ls_waddr = i_q[SW-1:0];
		ls_wdata = 4'd0;
		sl_we    = 1'b0;
		ss_we    = 1'b0;
		sl_waddr = fill_idx[SW-1:0];
		sl_wdata = ls_rd_q;
		ft_we    = 1'b0;
		ft_waddr = i_q[FAST_LOOKUP_BITS-1:0];
		ft_wdata = 13'd0;
		case (state_q)
			S_RCLR: begin
				ls_we    = (i_q < CW'(SYMBOL_COUNT));
				sl_we    = ls_we;
				sl_waddr = i_q[SW-1:0];
				sl_wdata = 4'd0;
				ft_we    = (i_q < CW'(FAST_SIZE));
			end
			S_IDLE: begin
				ls_we    = accept && (req.cmd == CMD_LOAD)
				        && ({1'b0, req.symbol} < 10'(SYMBOL_COUNT));
				ls_waddr = req.symbol[SW-1:0];
				ls_wdata = req.code_length;
			end
			S_CCLR: ls_we = 1'b1;
			S_BFCLR: ft_we = 1'b1;
			S_FLEN: begin
				sl_we = (ls_rd_q != 4'd0) && fill_idx_ok;
				ss_we = sl_we;
			end
			S_FFAST: begin
				ft_we    = 1'b1;
				ft_waddr = r_q[FAST_LOOKUP_BITS-1:0];
				ft_wdata = {ls_rd_q, cur_sym};
			end
			default: ;
		endcase
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (ls_we) length_store[ls_waddr] <= ls_wdata;
		ls_rd_q <= length_store[i_q[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (sl_we) sorted_lengths[sl_waddr] <= sl_wdata;
		if (ss_we) sorted_symbols[sl_waddr] <= cur_sym;
		sl_rd_q <= sorted_lengths[idx_q[SW-1:0]];
		ss_rd_q <= sorted_symbols[idx_q[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ft_we) fast_table[ft_waddr] <= ft_wdata;
		if (accept) ft_rd_q <= fast_table[req.bit_window[FAST_LOOKUP_BITS-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_RCLR;
			i_q      <= '0;
			len_q    <= '0;
			code_q   <= '0;
			total_q  <= '0;
			r_q      <= '0;
			win_q    <= '0;
			rev_q    <= '0;
			idx_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
			for (int k = 0; k < 16; k++) begin
				counts_q[k]      <= '0;
				next_code_q[k]   <= '0;
				first_code_q[k]  <= '0;
				first_index_q[k] <= '0;
				max_code_q[k]    <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				// clearing pass after reset
				S_RCLR: begin
					if (i_last_all) begin
						i_q     <= '0;
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						i_q <= '0;
						case (req.cmd)
							CMD_CLEAR: state_q <= S_CCLR;
							CMD_LOAD: begin
								done_q   <= 1'b1;
								result_q <= '{ST_OK, 9'd0, 4'd0};
							end
							CMD_BUILD: begin
								for (int k = 0; k < 16; k++) counts_q[k] <= '0;
								state_q <= S_BFCLR;
							end
							CMD_DECODE: begin
								win_q   <= req.bit_window;
								state_q <= S_DFAST;
							end
							default: ;
						endcase
					end
				end
				S_CCLR: begin
					if (i_last_sym) begin
						done_q   <= 1'b1;
						result_q <= '{ST_OK, 9'd0, 4'd0};
						state_q  <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				// build: zero the fast table
				S_BFCLR: begin
					if (i_last_fast) begin
						i_q     <= '0;
						state_q <= S_CNT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				// build: count lengths, read data lags the index by one
				S_CNT: begin
					if (i_q != '0 && ls_rd_q != 4'd0)
						counts_q[ls_rd_q] <= counts_q[ls_rd_q] + 1'b1;
					if (i_q == CW'(SYMBOL_COUNT)) begin
						len_q   <= 4'd1;
						state_q <= S_CHK;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_CHK: begin
					if (17'(counts_q[len_q]) > (17'd1 << len_q)) begin
						done_q   <= 1'b1;
						result_q <= '{ST_TOOMANY, 9'd0, 4'd0};
						state_q  <= S_IDLE;
					end else if (len_q == 4'(MAX_LEN)) begin
						len_q   <= 4'd1;
						code_q  <= '0;
						total_q <= '0;
						state_q <= S_GEN;
					end else begin
						len_q <= len_q + 1'b1;
					end
				end
				// build: first code, first index and limit per length
				S_GEN: begin
					next_code_q[len_q]   <= code_q[15:0];
					first_code_q[len_q]  <= code_q[15:0];
					first_index_q[len_q] <= total_q;
					if (counts_q[len_q] != '0 && code_new > (17'd1 << len_q)) begin
						done_q   <= 1'b1;
						result_q <= '{ST_OVERSUB, 9'd0, 4'd0};
						state_q  <= S_IDLE;
					end else begin
						max_code_q[len_q] <= 17'(code_new << len_shift);
						code_q            <= 17'(code_new << 1);
						total_q           <= total_q + counts_q[len_q];
						if (len_q == 4'(MAX_LEN)) begin
							i_q     <= '0;
							state_q <= S_FRD;
						end else begin
							len_q <= len_q + 1'b1;
						end
					end
				end
				// build: fill sorted and fast tables, one symbol at a time
				S_FRD: state_q <= S_FLEN;
				S_FLEN: begin
					if (ls_rd_q != 4'd0 && ls_rd_q <= 4'(FAST_LOOKUP_BITS)) begin
						r_q     <= RW'(rev_n(next_code_q[ls_rd_q], ls_rd_q));
						state_q <= S_FFAST;
					end else begin
						if (ls_rd_q != 4'd0)
							next_code_q[ls_rd_q] <= next_code_q[ls_rd_q] + 1'b1;
						if (i_last_sym) begin
							done_q   <= 1'b1;
							result_q <= '{ST_OK, 9'd0, 4'd0};
							state_q  <= S_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_FRD;
						end
					end
				end
				// replicate the entry over every fast slot sharing the prefix
				S_FFAST: begin
					if (r_next >= RW'(FAST_SIZE)) begin
						next_code_q[ls_rd_q] <= next_code_q[ls_rd_q] + 1'b1;
						if (i_last_sym) begin
							done_q   <= 1'b1;
							result_q <= '{ST_OK, 9'd0, 4'd0};
							state_q  <= S_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_FRD;
						end
					end else begin
						r_q <= r_next;
					end
				end
				// decode: fast table hit or start slow search
				S_DFAST: begin
					if (ft_rd_q != 13'd0) begin
						done_q   <= 1'b1;
						result_q <= '{ST_OK, ft_rd_q[8:0], ft_rd_q[12:9]};
						state_q  <= S_IDLE;
					end else if (SLOW_FIRST > MAX_LEN) begin
						done_q   <= 1'b1;
						result_q <= '{ST_BADCODE, 9'd0, 4'd0};
						state_q  <= S_IDLE;
					end else begin
						len_q   <= 4'(SLOW_FIRST);
						rev_q   <= rev16(win_q);
						state_q <= S_DSRCH;
					end
				end
				// one limit compare per length
				S_DSRCH: begin
					if ({1'b0, rev_q} < max_code_q[len_q]) begin
						idx_q   <= idx_slow;
						state_q <= S_DIDX;
					end else if (len_q == 4'(MAX_LEN)) begin
						done_q   <= 1'b1;
						result_q <= '{ST_BADCODE, 9'd0, 4'd0};
						state_q  <= S_IDLE;
					end else begin
						len_q <= len_q + 1'b1;
					end
				end
				S_DIDX: begin
					if (idx_q < 18'sd0 || idx_q >= $signed(18'(SYMBOL_COUNT))) begin
						done_q   <= 1'b1;
						result_q <= '{ST_BADCODE, 9'd0, 4'd0};
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_DCHK;
					end
				end
				S_DCHK: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (sl_rd_q == len_q)
						result_q <= '{ST_OK, ss_rd_q, len_q};
					else
						result_q <= '{ST_BADCODE, 9'd0, 4'd0};
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// bits are consumed only on a good decode
	a_used_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.consumed_bits != 4'd0) |-> result.status == ST_OK)
		else $error("consumed bits on a failed result");

	// failures carry no symbol and no length
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |->
		(result.decoded_symbol == 9'd0 && result.consumed_bits == 4'd0))
		else $error("failed result with payload");

	// busy only rises on an accepted request
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without a request");
`endif

endmodule
